### rtl/raw_frame_stream_deframer_assert.svh
// assertion macros used by the checker file rfsd_checker.sv
`ifndef RAW_FRAME_STREAM_DEFRAMER_ASSERT_SVH
`define RAW_FRAME_STREAM_DEFRAMER_ASSERT_SVH

// a stalled valid item keeps its valid and its payload
`define RFSD_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("rfsd: stalled item changed");

// a condition on one cycle implies another on the same cycle
`define RFSD_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (prop)) \
        else $error("rfsd: implication failed");

`endif

### rtl/rfsd_pkg.sv
package rfsd_pkg;

    // result kinds
    localparam logic [1:0] KIND_DESC = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // header error codes
    localparam logic [2:0] ERR_ID      = 3'd0;
    localparam logic [2:0] ERR_DIM     = 3'd1;
    localparam logic [2:0] ERR_FORMAT  = 3'd2;
    localparam logic [2:0] ERR_STRIDE  = 3'd3;
    localparam logic [2:0] ERR_PAYLOAD = 3'd4;

    // header constants
    localparam logic [31:0] FRAME_MAGIC       = 32'h4641_4b49;
    localparam logic [31:0] FRAME_VERSION     = 32'd1;
    localparam logic [31:0] FRAME_MAX_PAYLOAD = 32'h1000_0000;
    localparam logic [31:0] DIM_MAX           = 32'h0000_ffff;
    localparam logic [4:0]  HDR_LAST_BYTE     = 5'd31;

    // output tdata layout, lowest field first
    localparam int TD_ERR_LO    = 0;
    localparam int TD_WIDTH_LO  = 3;
    localparam int TD_HEIGHT_LO = 19;
    localparam int TD_FMT_LO    = 35;
    localparam int TD_STRIDE_LO = 38;
    localparam int TD_PAY_LO    = 70;
    localparam int TD_DATA_LO   = 99;
    localparam int TD_USED_W    = 107;
    localparam int OUT_TDATA_W  = 112;

    // default depth of the queue between front and back
    localparam int RFSD_QUEUE_DEPTH = 2;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [2:0]  pixel_format;
        logic [31:0] line_stride;
        logic [28:0] payload_length;
        logic [7:0]  data_byte;
        logic        last;
    } t_item;

    function automatic logic [31:0] fcc(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d);
        fcc = {d, c, b, a};
    endfunction

    // supported 4-byte formats, index is the pixel format code
    localparam logic [31:0] FOURCC_TABLE [8] = '{
        fcc("X", "R", "2", "4"), fcc("X", "B", "2", "4"),
        fcc("R", "X", "2", "4"), fcc("B", "X", "2", "4"),
        fcc("A", "R", "2", "4"), fcc("A", "B", "2", "4"),
        fcc("R", "A", "2", "4"), fcc("B", "A", "2", "4")
    };

endpackage

### rtl/rfsd_front.sv
module rfsd_front
    import rfsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    input  logic [31:0] i_display_select,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    // parser modes
    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_PASS   = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;
    localparam logic [1:0] MODE_ERROR  = 2'd3;

    logic [1:0]  r_mode, n_mode;
    logic [4:0]  r_cnt, n_cnt;
    logic [28:0] r_remain, n_remain;
    logic [31:0] r_words [8];

    // header checks precomputed from words that are complete before the last byte
    logic        r_bad_id, r_bad_dim, r_fmt_hit, r_stride_small;
    logic [2:0]  r_fmt;
    logic [47:0] r_prod;
    logic        n_fmt_hit;
    logic [2:0]  n_fmt;

    logic        accept;
    logic [1:0]  mode_eff;
    logic [4:0]  cnt_eff;
    logic        hdr_we;
    logic [31:0] pay_word;
    logic        pay_bad;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign mode_eff = i_start ? MODE_HEADER : r_mode;
    assign cnt_eff  = i_start ? 5'd0 : r_cnt;
    assign pay_word = {i_byte, r_words[7][23:0]};
    assign pay_bad  = (pay_word == 32'd0) || (pay_word > FRAME_MAX_PAYLOAD);

    // fourcc lookup
    always_comb begin
        n_fmt_hit = 1'b0;
        n_fmt     = 3'd0;
        for (int k = 0; k < 8; k++) begin
            if (r_words[5] == FOURCC_TABLE[k]) begin
                n_fmt_hit = 1'b1;
                n_fmt     = 3'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bad_id  <= (r_words[0] != FRAME_MAGIC) || (r_words[1] != FRAME_VERSION);
        r_bad_dim <= (r_words[3] == 32'd0) || (r_words[3] > DIM_MAX) ||
                     (r_words[4] == 32'd0) || (r_words[4] > DIM_MAX) ||
                     (r_words[6] == 32'd0);
        r_fmt_hit <= n_fmt_hit;
        r_fmt     <= n_fmt;
        r_stride_small <= r_words[6] < {14'd0, r_words[3][15:0], 2'b00};
        r_prod    <= r_words[4][15:0] * r_words[6];
    end

    // per item classification
    always_comb begin
        n_mode   = r_mode;
        n_cnt    = r_cnt;
        n_remain = r_remain;
        hdr_we   = 1'b0;
        o_push   = 1'b0;
        o_item   = '0;
        if (accept) begin
            n_mode = mode_eff;
            n_cnt  = cnt_eff;
            case (mode_eff)
                MODE_HEADER: begin
                    hdr_we = 1'b1;
                    n_cnt  = cnt_eff + 5'd1;
                    if (cnt_eff == HDR_LAST_BYTE) begin
                        o_item.kind = KIND_ERR;
                        if (r_bad_id) begin
                            o_item.error_code = ERR_ID;
                        end else if (r_bad_dim || pay_bad) begin
                            o_item.error_code = ERR_DIM;
                        end else if (!r_fmt_hit) begin
                            o_item.error_code = ERR_FORMAT;
                        end else if (r_stride_small) begin
                            o_item.error_code = ERR_STRIDE;
                        end else if ({16'd0, pay_word} < r_prod) begin
                            o_item.error_code = ERR_PAYLOAD;
                        end else begin
                            o_item.kind = KIND_DESC;
                        end
                        if (o_item.kind == KIND_ERR) begin
                            o_push = 1'b1;
                            n_mode = MODE_ERROR;
                        end else begin
                            n_remain = pay_word[28:0];
                            if (r_words[2] == i_display_select) begin
                                o_push              = 1'b1;
                                n_mode              = MODE_PASS;
                                o_item.frame_width  = r_words[3][15:0];
                                o_item.frame_height = r_words[4][15:0];
                                o_item.pixel_format = r_fmt;
                                o_item.line_stride  = r_words[6];
                                o_item.payload_length = pay_word[28:0];
                            end else begin
                                o_item = '0;
                                n_mode = MODE_SKIP;
                            end
                        end
                    end
                end
                MODE_PASS: begin
                    o_push           = 1'b1;
                    o_item.kind      = KIND_DATA;
                    o_item.data_byte = i_byte;
                    n_remain         = r_remain - 29'd1;
                    if (r_remain == 29'd1) begin
                        o_item.last = 1'b1;
                        n_mode      = MODE_HEADER;
                        n_cnt       = 5'd0;
                    end
                end
                MODE_SKIP: begin
                    n_remain = r_remain - 29'd1;
                    if (r_remain == 29'd1) begin
                        n_mode = MODE_HEADER;
                        n_cnt  = 5'd0;
                    end
                end
                default: begin
                    n_mode = MODE_ERROR;
                end
            endcase
        end
    end

    // header byte store
    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_words[cnt_eff[4:2]][8 * cnt_eff[1:0] +: 8] <= i_byte;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_HEADER;
            r_cnt    <= 5'd0;
            r_remain <= 29'd0;
        end else begin
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
            r_remain <= n_remain;
        end
    end

endmodule

### rtl/rfsd_queue.sv
module rfsd_queue
    import rfsd_pkg::*;
#(
    parameter int DEPTH = RFSD_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // entry store
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/rfsd_back.sv
module rfsd_back
    import rfsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_item                  i_item,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic [1:0]             o_tuser,
    output logic                   o_tlast
);

    logic  r_valid;
    t_item r_item;

    assign o_pop = i_valid && (!r_valid || i_tready);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    // pack fields into the bus layout
    always_comb begin
        o_tdata = '0;
        o_tdata[TD_ERR_LO    +: 3]  = r_item.error_code;
        o_tdata[TD_WIDTH_LO  +: 16] = r_item.frame_width;
        o_tdata[TD_HEIGHT_LO +: 16] = r_item.frame_height;
        o_tdata[TD_FMT_LO    +: 3]  = r_item.pixel_format;
        o_tdata[TD_STRIDE_LO +: 32] = r_item.line_stride;
        o_tdata[TD_PAY_LO    +: 29] = r_item.payload_length;
        o_tdata[TD_DATA_LO   +: 8]  = r_item.data_byte;
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_item.kind;
    assign o_tlast  = r_item.last;

endmodule

### rtl/raw_frame_stream_deframer.sv
// Raw frame stream deframer: accepts one stream byte per cycle, every byte of a header,
// a payload or an error wait alike, so a continuous stream flows at one item per clock.
// The 32-byte header is checked in the cycle of its last byte from check flags and a
// height times stride product that are registered from the earlier header words; only
// the payload word checks and the display compare sit in that cycle. Results pass
// through a short queue and an output register, and input keeps being taken while the
// output is stalled until the queue fills. The display select register is written
// through the config channel, which is always ready; there is no clearing pass after
// reset.
module raw_frame_stream_deframer
    import rfsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = RFSD_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // byte_in
    input  logic                   s_axis_tuser,  // stream_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // error_code, frame_width, frame_height, pixel_format, line_stride,
    // payload_length, data_byte, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]             m_axis_tuser,  // kind
    output logic                   m_axis_tlast,  // last
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [31:0]            i_cfg_data     // display_select
);

    logic [31:0] r_display_select;
    logic        q_full, q_valid, q_pop, f_push;
    t_item       f_item, q_item;

    // display select register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_select <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_display_select <= i_cfg_data;
        end
    end

    // header parsing and classification
    rfsd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_byte           (s_axis_tdata),
        .i_start          (s_axis_tuser),
        .i_display_select (r_display_select),
        .i_full           (q_full),
        .o_push           (f_push),
        .o_item           (f_item)
    );

    // result queue
    rfsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    // output stage
    rfsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

### rtl/rfsd_checker.sv
`include "raw_frame_stream_deframer_assert.svh"

module rfsd_checker
    import rfsd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser,
    input logic                   m_axis_tlast
);

    logic desc_ok, err_ok, last_ok;

    // descriptor carries nonzero sizes and a stride that covers the width
    assign desc_ok = (m_axis_tdata[TD_WIDTH_LO +: 16] != 16'd0) &&
                     (m_axis_tdata[TD_HEIGHT_LO +: 16] != 16'd0) &&
                     (m_axis_tdata[TD_STRIDE_LO +: 32] >=
                      {14'd0, m_axis_tdata[TD_WIDTH_LO +: 16], 2'b00});
    // error carries a known code and nothing else
    assign err_ok  = (m_axis_tdata[TD_ERR_LO +: 3] <= ERR_PAYLOAD) &&
                     (m_axis_tdata[TD_USED_W-1:TD_WIDTH_LO] == '0) && !m_axis_tlast;
    // last only marks a payload byte
    assign last_ok = (m_axis_tuser == KIND_DATA);

    `RFSD_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, m_axis_tvalid, m_axis_tready, {m_axis_tdata, m_axis_tuser, m_axis_tlast})
    `RFSD_ASSERT_IMPLY(a_desc_fields, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == KIND_DESC), desc_ok)
    `RFSD_ASSERT_IMPLY(a_err_fields, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == KIND_ERR), err_ok)
    `RFSD_ASSERT_IMPLY(a_last_kind, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, last_ok)

endmodule

bind raw_frame_stream_deframer rfsd_checker u_rfsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/raw_frame_stream_deframer_checker.sv
module raw_frame_stream_deframer_checker
    import rfsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [7:0]             i_in_byte,
    input  logic                   i_in_start,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    input  logic [1:0]             i_out_kind,
    input  logic                   i_out_last,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [31:0]            i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef enum logic [1:0] {PM_HEADER, PM_PASS, PM_SKIP, PM_ERROR} t_parse_mode;

    // shadow copy of the deframer state
    t_parse_mode  mode;
    logic [4:0]   hdr_count;
    logic [31:0]  hdr_words [8];
    logic [28:0]  bytes_left;
    logic [31:0]  display_sel;

    // results still owed by the block, oldest first
    t_item        frame_results [$];
    int           fails = 0;
    int           results_seen = 0;

    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= 40) begin
            $display("[%0t] result %0d: %s", $time, results_seen, msg);
        end
    endtask

    // header checks in priority order, returns 1 when the header is rejected
    function automatic logic header_fault(output logic [2:0] code, output logic [2:0] fmt);
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] stride;
        logic [31:0] pay;
        logic        known;
        w      = hdr_words[3];
        h      = hdr_words[4];
        stride = hdr_words[6];
        pay    = hdr_words[7];
        fmt    = '0;
        known  = 1'b0;
        code   = ERR_ID;
        if (hdr_words[0] != FRAME_MAGIC || hdr_words[1] != FRAME_VERSION) return 1'b1;
        code = ERR_DIM;
        if (w == 0 || w > DIM_MAX || h == 0 || h > DIM_MAX || stride == 0 ||
            pay == 0 || pay > FRAME_MAX_PAYLOAD) return 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (hdr_words[5] == FOURCC_TABLE[i]) begin
                fmt   = 3'(i);
                known = 1'b1;
            end
        end
        code = ERR_FORMAT;
        if (!known) return 1'b1;
        code = ERR_STRIDE;
        if (64'(stride) < 64'(w) * 64'd4) return 1'b1;
        code = ERR_PAYLOAD;
        if (64'(pay) < 64'(h) * 64'(stride)) return 1'b1;
        return 1'b0;
    endfunction

    // advance the shadow state by one input item and queue what it produces
    task automatic deframe_byte(input logic [7:0] b, input logic start);
        t_item      r;
        logic [2:0] code;
        logic [2:0] fmt;
        r = '0;
        if (start) begin
            mode      = PM_HEADER;
            hdr_count = '0;
        end
        case (mode)
            PM_HEADER: begin
                hdr_words[hdr_count[4:2]][{hdr_count[1:0], 3'b000} +: 8] = b;
                hdr_count = hdr_count + 5'd1;
                if (hdr_count == 0) begin
                    if (header_fault(code, fmt)) begin
                        mode         = PM_ERROR;
                        r.kind       = KIND_ERR;
                        r.error_code = code;
                        frame_results.push_back(r);
                    end else begin
                        bytes_left = hdr_words[7][28:0];
                        if (hdr_words[2] != display_sel) begin
                            mode = PM_SKIP;
                        end else begin
                            mode             = PM_PASS;
                            r.kind           = KIND_DESC;
                            r.frame_width    = hdr_words[3][15:0];
                            r.frame_height   = hdr_words[4][15:0];
                            r.pixel_format   = fmt;
                            r.line_stride    = hdr_words[6];
                            r.payload_length = hdr_words[7][28:0];
                            frame_results.push_back(r);
                        end
                    end
                end
            end
            PM_PASS, PM_SKIP: begin
                if (bytes_left != 0) bytes_left = bytes_left - 29'd1;
                if (mode == PM_PASS) begin
                    r.kind      = KIND_DATA;
                    r.data_byte = b;
                    r.last      = (bytes_left == 0);
                    frame_results.push_back(r);
                end
                if (bytes_left == 0) begin
                    mode      = PM_HEADER;
                    hdr_count = '0;
                end
            end
            default: begin
            end
        endcase
    endtask

    // compare one output item against the oldest expectation
    task automatic check_result();
        t_item got;
        t_item want;
        got                = '0;
        got.kind           = i_out_kind;
        got.error_code     = i_out_data[TD_ERR_LO +: 3];
        got.frame_width    = i_out_data[TD_WIDTH_LO +: 16];
        got.frame_height   = i_out_data[TD_HEIGHT_LO +: 16];
        got.pixel_format   = i_out_data[TD_FMT_LO +: 3];
        got.line_stride    = i_out_data[TD_STRIDE_LO +: 32];
        got.payload_length = i_out_data[TD_PAY_LO +: 29];
        got.data_byte      = i_out_data[TD_DATA_LO +: 8];
        got.last           = i_out_last;
        results_seen++;
        if (frame_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result of kind %0d", got.kind));
            return;
        end
        want = frame_results.pop_front();
        if (got.kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.error_code != want.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      got.error_code, want.error_code));
        if (got.frame_width != want.frame_width)
            report_mismatch($sformatf("frame_width %0d, expected %0d",
                                      got.frame_width, want.frame_width));
        if (got.frame_height != want.frame_height)
            report_mismatch($sformatf("frame_height %0d, expected %0d",
                                      got.frame_height, want.frame_height));
        if (got.pixel_format != want.pixel_format)
            report_mismatch($sformatf("pixel_format %0d, expected %0d",
                                      got.pixel_format, want.pixel_format));
        if (got.line_stride != want.line_stride)
            report_mismatch($sformatf("line_stride %0h, expected %0h",
                                      got.line_stride, want.line_stride));
        if (got.payload_length != want.payload_length)
            report_mismatch($sformatf("payload_length %0h, expected %0h",
                                      got.payload_length, want.payload_length));
        if (got.data_byte != want.data_byte)
            report_mismatch($sformatf("data_byte %0h, expected %0h",
                                      got.data_byte, want.data_byte));
        if (got.last != want.last)
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask

    // watch the three channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode        = PM_HEADER;
            hdr_count   = '0;
            bytes_left  = '0;
            display_sel = '0;
            for (int i = 0; i < 8; i++) hdr_words[i] = '0;
            frame_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) display_sel = i_cfg_data;
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) deframe_byte(i_in_byte, i_in_start);
        end
        o_pending    = frame_results.size();
        o_fail_count = fails;
    end

endmodule

### tb/raw_frame_stream_deframer_tb.sv
module raw_frame_stream_deframer_tb;
    import rfsd_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;

    // header defects that the random part can inject
    typedef enum int {
        FLAW_MAGIC, FLAW_VERSION, FLAW_WIDTH, FLAW_HEIGHT, FLAW_STRIDE_ZERO,
        FLAW_PAYLOAD_RANGE, FLAW_FOURCC, FLAW_STRIDE_SHORT, FLAW_PAYLOAD_SHORT
    } t_flaw;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // byte_in
    logic                   s_axis_tuser;   // stream_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // error_code, frame_width, frame_height, pixel_format, line_stride,
    // payload_length, data_byte, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;   // kind
    logic                   m_axis_tlast;   // last
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [31:0]            i_cfg_data;     // display_select

    int                     n_fail;
    int                     n_pending;
    int                     stall_cycles;
    int                     fed_bytes;
    logic                   calm;
    logic                   need_start;
    logic [31:0]            sel;
    logic [31:0]            hw [8];

    raw_frame_stream_deframer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    raw_frame_stream_deframer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_in_start   (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_kind   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (n_fail),
        .o_pending    (n_pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // output side backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 37);
    end

    // watchdog on cycles with no item moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one input item, with random idle cycles ahead of it
    task automatic put_byte(input logic [7:0] b, input logic start);
        while (!calm && $urandom_range(99) < 37) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        fed_bytes++;
        @(negedge i_clk);
    endtask

    task automatic stop_feed();
        s_axis_tvalid <= 1'b0;
    endtask

    // first n header bytes, little endian, start flag on byte 0
    task automatic send_header(input logic start, input int n);
        for (int i = 0; i < n; i++) begin
            put_byte(hw[i / 4][8 * (i % 4) +: 8], start && i == 0);
        end
    endtask

    task automatic send_bytes(input int n, input int start_pct);
        for (int i = 0; i < n; i++) begin
            put_byte(8'($urandom), $urandom_range(99) < start_pct);
        end
    endtask

    task automatic set_header(input logic [31:0] disp, input logic [31:0] w,
                              input logic [31:0] h, input logic [31:0] stride,
                              input logic [31:0] pay, input int fmt);
        hw[0] = FRAME_MAGIC;
        hw[1] = FRAME_VERSION;
        hw[2] = disp;
        hw[3] = w;
        hw[4] = h;
        hw[5] = FOURCC_TABLE[fmt];
        hw[6] = stride;
        hw[7] = pay;
    endtask

    // small well-formed header with a little slack in stride and payload
    task automatic rand_header(input logic [31:0] disp);
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] stride;
        w      = $urandom_range(2, 1);
        h      = $urandom_range(2, 1);
        stride = w * 4 + $urandom_range(2);
        set_header(disp, w, h, stride, h * stride + $urandom_range(3), $urandom_range(7));
    endtask

    function automatic logic [31:0] other_display();
        return sel ^ ($urandom | (32'd1 << $urandom_range(31)));
    endfunction

    // spoil one field of a well-formed small header
    task automatic break_header(input t_flaw flaw);
        logic [31:0] v;
        logic        known;
        case (flaw)
            FLAW_MAGIC:         hw[0] = hw[0] ^ ($urandom | (32'd1 << $urandom_range(31)));
            FLAW_VERSION: begin
                do begin
                    hw[1] = $urandom_range(3) == 0 ? $urandom : $urandom_range(7);
                end while (hw[1] == FRAME_VERSION);
            end
            FLAW_WIDTH:
                hw[3] = $urandom_range(1) ? 32'd0 : ($urandom | (32'h1_0000 << $urandom_range(15)));
            FLAW_HEIGHT:
                hw[4] = $urandom_range(1) ? 32'd0 : ($urandom | (32'h1_0000 << $urandom_range(15)));
            FLAW_STRIDE_ZERO:   hw[6] = 32'd0;
            FLAW_PAYLOAD_RANGE:
                hw[7] = $urandom_range(1) ? 32'd0 : $urandom_range(32'hffff_ffff, FRAME_MAX_PAYLOAD + 1);
            FLAW_FOURCC: begin
                do begin
                    if ($urandom_range(1)) begin
                        v = FOURCC_TABLE[$urandom_range(7)] ^ (32'd1 << $urandom_range(31));
                    end else begin
                        v = $urandom;
                    end
                    known = 1'b0;
                    for (int i = 0; i < 8; i++) begin
                        if (FOURCC_TABLE[i] == v) known = 1'b1;
                    end
                end while (known);
                hw[5] = v;
            end
            FLAW_STRIDE_SHORT:  hw[6] = $urandom_range(hw[3] * 4 - 1, 1);
            FLAW_PAYLOAD_SHORT: hw[7] = $urandom_range(hw[4] * hw[6] - 1, 1);
            default: begin
            end
        endcase
    endtask

    // register write once the block has drained
    task automatic write_display(input logic [31:0] v);
        stop_feed();
        while (n_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        sel = v;
    endtask

    // mostly well-formed frames, some aborted, broken or plain noise
    task automatic random_traffic(input int quota);
        int   goal;
        int   r;
        logic start;
        goal = fed_bytes + quota;
        while (fed_bytes < goal) begin
            r     = $urandom_range(99);
            start = need_start || ($urandom_range(4) == 0);
            if (r < 70) begin
                rand_header(r < 55 ? sel : other_display());
                send_header(start, 32);
                send_bytes(hw[7], 0);
                need_start = 1'b0;
            end else if (r < 78) begin
                rand_header($urandom_range(1) ? sel : other_display());
                if ($urandom_range(1)) begin
                    send_header(start, 32);
                    send_bytes($urandom_range(hw[7] - 1, 0), 0);
                end else begin
                    send_header(start, $urandom_range(31, 1));
                end
                need_start = 1'b1;
            end else if (r < 92) begin
                rand_header(sel);
                break_header(t_flaw'($urandom_range(FLAW_PAYLOAD_SHORT)));
                send_header(start, 32);
                send_bytes($urandom_range(6), 0);
                need_start = 1'b1;
            end else begin
                send_bytes($urandom_range(20, 1), 10);
                need_start = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        fed_bytes     = 0;
        calm          = 1'b0;
        need_start    = 1'b1;
        sel           = '0;
        for (int i = 0; i < 8; i++) hw[i] = '0;

        // reset
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // display zero: basic frames, every header defect, field extremes
        write_display(32'd0);
        set_header(32'd0, 1, 1, 4, 4, 0);
        send_header(1'b1, 32);
        send_bytes(4, 0);
        set_header(32'd0, 2, 1, 8, 8, 7);
        send_header(1'b0, 32);
        send_bytes(8, 0);
        // other display is skipped
        set_header(32'd5, 1, 1, 4, 4, 3);
        send_header(1'b0, 32);
        send_bytes(4, 0);
        // stream start during header collection
        set_header(32'd0, 1, 1, 4, 4, 1);
        send_header(1'b0, 10);
        set_header(32'd0, 1, 2, 5, 12, 2);
        send_header(1'b1, 32);
        send_bytes(12, 0);
        // each defect, then ignored bytes in the error wait
        for (int f = 0; f <= FLAW_PAYLOAD_SHORT; f++) begin
            rand_header(32'd0);
            break_header(t_flaw'(f));
            send_header(1'b1, 32);
            send_bytes(3, 0);
        end
        // widest frame and largest payload, cut short by stream start
        set_header(32'd0, 65535, 1, 262140, 262140, 4);
        send_header(1'b1, 32);
        send_bytes(3, 0);
        set_header(32'd0, 1, 1, 4, FRAME_MAX_PAYLOAD, 5);
        send_header(1'b1, 32);
        send_bytes(2, 0);
        set_header(32'd0, 1, 65535, 4, 262140, 6);
        send_header(1'b1, 32);
        send_bytes(2, 0);
        // skipped frame cut short by stream start
        set_header(32'd9, 1, 65535, 4, 262140, 6);
        send_header(1'b1, 32);
        send_bytes(2, 0);
        // payload checks with products beyond 32 bits, then a payload one above the maximum
        set_header(32'd0, 65535, 65535, 32'hffff_ffff, FRAME_MAX_PAYLOAD, 0);
        send_header(1'b1, 32);
        set_header(32'd0, 1, 4096, 32'h0010_0001, FRAME_MAX_PAYLOAD, 1);
        send_header(1'b1, 32);
        set_header(32'd0, 1, 1, 4, FRAME_MAX_PAYLOAD + 1, 0);
        send_header(1'b1, 32);
        need_start = 1'b1;
        random_traffic(200);

        // all-ones display
        write_display(32'hffff_ffff);
        set_header(32'hffff_ffff, 1, 1, 4, 4, 2);
        send_header(1'b1, 32);
        send_bytes(4, 0);
        set_header(32'd0, 1, 1, 4, 4, 2);
        send_header(1'b0, 32);
        send_bytes(4, 0);
        need_start = 1'b0;
        random_traffic(170);

        // random display, no idle cycles on either side
        calm = 1'b1;
        write_display($urandom);
        random_traffic(170);
        calm = 1'b0;

        write_display($urandom);
        random_traffic(170);

        // drain and verdict
        stop_feed();
        while (n_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/rfsd_pkg.sv
rtl/rfsd_front.sv
rtl/rfsd_queue.sv
rtl/rfsd_back.sv
rtl/raw_frame_stream_deframer.sv
rtl/rfsd_checker.sv
tb/raw_frame_stream_deframer_checker.sv
tb/raw_frame_stream_deframer_tb.sv
